// File: rtl/dbld_pkg.sv
// package: types, codes and reset constants of the button led dimmer
package dbld_pkg;

   localparam int TIME_BITS_DEF   = 32;
   localparam int MAX_TIME_BITS   = 64;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int NUM_BUTTONS     = 3;
   localparam int LEVEL_W         = 12;
   localparam int CSR_DATA_W      = 12;
   localparam int CSR_INDEX_W     = 2;
   localparam int BUTTON_W        = 2;

   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [BUTTON_W-1:0] BTN_RIGHT  = 2'd0;
   localparam logic [BUTTON_W-1:0] BTN_MIDDLE = 2'd1;
   localparam logic [BUTTON_W-1:0] BTN_LEFT   = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MID      = 2'd3;

   localparam logic [7:0]         DEBOUNCE_RST   = 8'd20;
   localparam logic [7:0]         STEP_RST       = 8'd4;
   localparam logic [LEVEL_W-1:0] MAX_RST        = 12'd1000;
   localparam logic [LEVEL_W-1:0] MID_RST        = 12'd500;
   localparam logic [LEVEL_W-1:0] BRIGHTNESS_RST = 12'd500;

   typedef struct packed {
      logic                op;
      logic [BUTTON_W-1:0] button;
      logic                rise;
      logic                fall;
      logic [31:0]         now_ms;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] duty_level;
      logic               lights_on;
   } rsp_type;

   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_RIGHT  = 3'd1,
      ACT_MIDDLE = 3'd2,
      ACT_LEFT   = 3'd3,
      ACT_TICK   = 3'd4
   } act_kind_type;

   typedef struct packed {
      act_kind_type        kind;
      logic [BUTTON_W-1:0] button;
      logic                rise;
      logic                fall;
      logic [31:0]         now_ms;
   } action_type;

   typedef struct packed {
      logic                   valid;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
   } csr_write_type;

endpackage

// File: rtl/dbld_fifo.sv
// small register queue with registered storage and occupancy count
module dbld_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: rtl/dbld_front.sv
// front end: accepts request beats, classifies them and queues the actions
module dbld_front import dbld_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  req_type    req_data,
   output logic       req_full,
   output logic       act_valid,
   output action_type act,
   input  logic       act_pop
);

   action_type   classified;
   act_kind_type kind;
   logic         act_empty;

   always_comb begin
      if (req_data.op == OP_TICK) begin
         kind = ACT_TICK;
      end else begin
         unique case (req_data.button)
            BTN_RIGHT:  kind = ACT_RIGHT;
            BTN_MIDDLE: kind = ACT_MIDDLE;
            BTN_LEFT:   kind = ACT_LEFT;
            default:    kind = ACT_NONE;
         endcase
      end
   end

   always_comb begin
      classified.kind   = kind;
      classified.button = req_data.button;
      classified.rise   = req_data.rise;
      classified.fall   = req_data.fall;
      classified.now_ms = req_data.now_ms;
   end

   dbld_fifo #(
      .WIDTH ($bits(action_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_act_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (classified),
      .full  (req_full),
      .pop   (act_pop),
      .rdata (act),
      .empty (act_empty)
   );

   assign act_valid = !act_empty;

endmodule

// File: rtl/dbld_back.sv
// back end: debounce, switch and ramp state, one action per clock while the response queue is not full
module dbld_back import dbld_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  csr_write_type csr,
   input  logic          act_valid,
   input  action_type    act,
   output logic          act_pop,
   input  logic          out_full,
   output logic          out_push,
   output rsp_type       out_data
);

   logic [7:0]           debounce_ff, step_ff;
   logic [LEVEL_W-1:0]   max_ff, mid_ff;
   logic [TIME_BITS-1:0] last_ff [NUM_BUTTONS];
   logic [TIME_BITS-1:0] last_in [NUM_BUTTONS];
   logic [LEVEL_W-1:0]   bright_ff, bright_in;
   logic                 on_ff, on_in;
   logic                 rheld_ff, rheld_in;
   logic                 lheld_ff, lheld_in;

   logic                 do_step;
   logic [MAX_TIME_BITS-1:0] now_wide;
   logic [TIME_BITS-1:0] now_t, last_sel, diff;
   logic                 pass, rise_ok, fall_ok, edge_ok;
   logic [LEVEL_W:0]     up_sum;
   logic [LEVEL_W-1:0]   lvl_up, lvl_dn, step_lvl;

   assign do_step  = act_valid && !out_full;
   assign act_pop  = do_step;
   assign out_push = do_step;

   assign now_wide = {{(MAX_TIME_BITS - 32){1'b0}}, act.now_ms};
   assign now_t    = now_wide[TIME_BITS-1:0];

   always_comb begin
      unique case (act.button)
         BTN_RIGHT: last_sel = last_ff[0];
         BTN_LEFT:  last_sel = last_ff[2];
         default:   last_sel = last_ff[1];
      endcase
   end

   // both edges in one beat: the fall sees the timestamp the rise just set
   assign diff    = now_t - last_sel;
   assign pass    = (diff >= TIME_BITS'(debounce_ff));
   assign rise_ok = act.rise && pass;
   assign fall_ok = act.fall && (rise_ok ? (debounce_ff == '0) : pass);
   assign edge_ok = rise_ok || fall_ok;

   assign step_lvl = {{(LEVEL_W - 8){1'b0}}, step_ff};
   assign up_sum   = {1'b0, bright_ff} + {1'b0, step_lvl};

   always_comb begin
      if (rheld_ff) begin
         lvl_up = (up_sum > {1'b0, max_ff}) ? max_ff : up_sum[LEVEL_W-1:0];
      end else begin
         lvl_up = bright_ff;
      end
      if (lheld_ff) begin
         lvl_dn = (lvl_up < step_lvl) ? '0 : lvl_up - step_lvl;
         if (lvl_dn > max_ff) begin
            lvl_dn = max_ff;
         end
      end else begin
         lvl_dn = lvl_up;
      end
   end

   always_comb begin
      last_in   = last_ff;
      bright_in = bright_ff;
      on_in     = on_ff;
      rheld_in  = rheld_ff;
      lheld_in  = lheld_ff;
      if (do_step) begin
         unique case (act.kind)
            ACT_RIGHT: begin
               if (edge_ok) begin
                  last_in[0] = now_t;
                  if (on_ff) begin
                     rheld_in = fall_ok;
                  end
               end
            end
            ACT_LEFT: begin
               if (edge_ok) begin
                  last_in[2] = now_t;
                  if (on_ff) begin
                     lheld_in = fall_ok;
                  end
               end
            end
            ACT_MIDDLE: begin
               if (edge_ok) begin
                  last_in[1] = now_t;
               end
               if (fall_ok) begin
                  if (!on_ff) begin
                     on_in = 1'b1;
                  end else if (bright_ff == '0) begin
                     bright_in = mid_ff;
                  end else begin
                     on_in = 1'b0;
                  end
               end
            end
            ACT_TICK: begin
               if (on_ff) begin
                  bright_in = lvl_dn;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_data.lights_on  = on_in;
      out_data.duty_level = on_in ? bright_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RST;
         step_ff     <= STEP_RST;
         max_ff      <= MAX_RST;
         mid_ff      <= MID_RST;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_DEBOUNCE: debounce_ff <= csr.wdata[7:0];
            CSR_STEP:     step_ff     <= csr.wdata[7:0];
            CSR_MAX:      max_ff      <= csr.wdata;
            CSR_MID:      mid_ff      <= csr.wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            last_ff[i] <= '0;
         end
         bright_ff <= BRIGHTNESS_RST;
         on_ff     <= 1'b0;
         rheld_ff  <= 1'b0;
         lheld_ff  <= 1'b0;
      end else begin
         last_ff   <= last_in;
         bright_ff <= bright_in;
         on_ff     <= on_in;
         rheld_ff  <= rheld_in;
         lheld_ff  <= lheld_in;
      end
   end

endmodule

// File: rtl/debounced_button_led_dimmer_unit.sv
// top level: debounced three-button led dimmer with request and response queues
//
// Requests are button edge beats (per-button debounce on the millisecond
// timestamp, rising edge checked before falling edge) or ramp ticks; every request gives
// exactly one response beat carrying the duty level and the on flag. One
// request is taken per clock while req_full is low, and the execute stage
// takes one action per clock while the response queue is not full. An accepted
// request is written into the action queue, then executed from there into the
// response queue, whose head drives the response ports. A full response queue
// holds the execute stage, and a full action queue raises req_full. Registers
// are written through the csr channel, which is always ready; write them only
// while the block is idle.
module debounced_button_led_dimmer_unit import dbld_pkg::*; #(
   parameter int TIME_BITS   = TIME_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  req_type                req_data,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   csr_write_type csr;
   action_type    act;
   logic          act_valid, act_pop;
   logic          out_full, out_push;
   rsp_type       out_data;

   assign csr_ready = 1'b1;

   always_comb begin
      csr.valid = csr_valid && csr_ready;
      csr.index = csr_index;
      csr.wdata = csr_wdata;
   end

   dbld_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .act_valid (act_valid),
      .act       (act),
      .act_pop   (act_pop)
   );

   dbld_back #(
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .act_valid (act_valid),
      .act       (act),
      .act_pop   (act_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   dbld_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule
